### hw/rtl/lsap_pkg.sv
// Shared constants and types for the line sensor array position unit.
// Used by lsap_div, lsap_cal and the top level; no other dependencies.
`timescale 1ns / 1ps

package lsap_pkg;

  // Array size and converter resolution
  localparam int MAX_SENSORS = 16;
  localparam int SAMPLE_BITS = 12;
  localparam int IDX_W       = $clog2(MAX_SENSORS);

  // Fixed field widths
  localparam int IN_IDX_W = 4;
  localparam int CNT_W    = 5;
  localparam int POS_W    = 14;
  localparam int IN_W     = ((IN_IDX_W + SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_W    = ((POS_W + 7) / 8) * 8;

  // Arithmetic constants
  localparam int unsigned SMAX      = (1 << SAMPLE_BITS) - 1;
  localparam int unsigned NORM_FULL = 1000;
  localparam int unsigned RANGE_MIN = 100;
  localparam int unsigned LINE_STEP = 100;
  localparam int NORM_W = 10;

  // Accumulators and shared divider sizes
  localparam int WSUM_W   = 28;
  localparam int WTOT_W   = 14;
  localparam int DVD_W    = 28;
  localparam int DVS_W    = (SAMPLE_BITS > WTOT_W) ? SAMPLE_BITS : WTOT_W;
  localparam int MUL_A_W  = (SAMPLE_BITS > NORM_W) ? SAMPLE_BITS : NORM_W;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  // Calibration store write and read
  typedef struct packed {
    logic                   en;
    logic [SAMPLE_BITS-1:0] value;
  } cal_wr_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] hi;
  } cal_rd_t;

endpackage

### hw/rtl/lsap_div.sv
// Shared restoring divider, two quotient bits per cycle.
// Depends on lsap_pkg for widths and the request/response structs.
`timescale 1ns / 1ps

module lsap_div
  import lsap_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int DIV_STEPS = (DVD_W + 1) / 2;
  localparam int STEP_CW   = $clog2(DIV_STEPS + 1);

  logic [DVS_W-1:0]   rem;
  logic [DVD_W-1:0]   quo;
  logic [DVS_W-1:0]   dvs;
  logic [STEP_CW-1:0] cnt;
  logic               busy;
  logic               done;
  logic [DVS_W-1:0]   rem_next;
  logic [DVD_W-1:0]   quo_next;
  logic [DVS_W:0]     trial;

  // Two shift-and-subtract steps per cycle
  always_comb begin
    rem_next = rem;
    quo_next = quo;
    trial    = '0;
    for (int k = 0; k < 2; k++) begin
      trial    = {rem_next, quo_next[DVD_W-1]};
      quo_next = {quo_next[DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        trial       = trial - {1'b0, dvs};
        quo_next[0] = 1'b1;
      end
      rem_next = trial[DVS_W-1:0];
    end
  end

  // Load operands on start, then iterate until the count runs out
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem  <= '0;
        quo  <= req.dividend;
        dvs  <= req.divisor;
        cnt  <= STEP_CW'(DIV_STEPS);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= rem_next;
        quo <= quo_next;
        cnt <= cnt - STEP_CW'(1);
        if (cnt == STEP_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

### hw/rtl/lsap_cal.sv
// Per-sensor calibration store: minimum, maximum and a range-good flag.
// Depends on lsap_pkg for sizes and the write/read structs.
`timescale 1ns / 1ps

module lsap_cal
  import lsap_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic [IDX_W-1:0]       idx,
  input  cal_wr_t                wr,
  output cal_rd_t                rd,
  output logic [MAX_SENSORS-1:0] good
);

  logic [SAMPLE_BITS-1:0] cal_min [MAX_SENSORS];
  logic [SAMPLE_BITS-1:0] cal_max [MAX_SENSORS];
  logic [SAMPLE_BITS-1:0] min_next;
  logic [SAMPLE_BITS-1:0] max_next;
  logic                   good_next;

  // Widen the range with the new sample
  always_comb begin
    min_next  = (wr.value < cal_min[idx]) ? wr.value : cal_min[idx];
    max_next  = (wr.value > cal_max[idx]) ? wr.value : cal_max[idx];
    good_next = (max_next > min_next) &&
                ((max_next - min_next) > SAMPLE_BITS'(RANGE_MIN));
  end

  // Hold calibration; reset to an empty range
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_SENSORS; i++) begin
        cal_min[i] <= SAMPLE_BITS'(SMAX);
        cal_max[i] <= '0;
      end
      good <= '0;
    end else if (wr.en) begin
      cal_min[idx] <= min_next;
      cal_max[idx] <= max_next;
      good[idx]    <= good_next;
    end
  end

  assign rd.lo = cal_min[idx];
  assign rd.hi = cal_max[idx];

endmodule

### hw/rtl/line_sensor_array_position_unit.sv
// Line sensor array position unit: calibration and weighted centroid.
// Calibration item: widens the stored range. Measure item: the normalizing divide is skipped
// with an empty range or a sample at or below the minimum; each divide runs on the shared
// two-bit-per-cycle divider. Last sensor of a scan: the position divide follows, skipped
// when no line was seen or the weight total is zero. One item at a time; s_axis_tready is
// low while an item is worked on or its result waits for the output register. Synchronous
// reset: empty calibration, cleared scan, sensor_count 16.
`timescale 1ns / 1ps

module line_sensor_array_position_unit
  import lsap_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // configuration: sensor_count
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data,
  // input items
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,  // sensor_index, adc_sample
  input  logic             s_axis_tuser,  // mode
  // result items
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,  // position
  output logic [1:0]       m_axis_tuser   // line_found, range_ok
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CAL,
    ST_MUL1,
    ST_NSTART,
    ST_NDIV,
    ST_MUL2,
    ST_ACC,
    ST_POS,
    ST_PDIV,
    ST_EMIT
  } state_t;

  state_t                 state;
  logic [CNT_W-1:0]       sensor_count;
  logic [IN_IDX_W-1:0]    idx_r;
  logic [SAMPLE_BITS-1:0] val_r;
  logic [DVD_W-1:0]       prod_r;
  logic [DVS_W-1:0]       range_r;
  logic [WTOT_W-1:0]      weight_r;
  logic [NORM_W-1:0]      norm_r;
  logic [WSUM_W-1:0]      weighted_sum;
  logic [WTOT_W-1:0]      weight_total;
  logic                   line_seen;
  logic [POS_W-1:0]       last_position;
  logic [POS_W-1:0]       pos_r;
  logic [POS_W-1:0]       out_pos;
  logic                   out_line;
  logic                   out_cal;
  logic                   out_valid;

  logic [CNT_W-1:0]       n_eff;
  logic [IN_IDX_W-1:0]    in_idx;
  logic [SAMPLE_BITS-1:0] in_raw;
  logic [MUL_A_W-1:0]     mul_a;
  logic [WTOT_W-1:0]      mul_b;
  logic [MUL_A_W+WTOT_W-1:0] mul_p;
  logic [WSUM_W:0]        wsum_add;
  logic [WTOT_W:0]        wtot_add;
  logic [POS_W:0]         full;
  logic [POS_W:0]         half;
  logic [NORM_W:0]        line_thr;
  logic                   pos_divide;
  logic [MAX_SENSORS-1:0] in_use;
  logic [MAX_SENSORS-1:0] good;
  logic                   cal_ok;
  div_req_t               div_req;
  div_rsp_t               div_rsp;
  cal_wr_t                cal_wr;
  cal_rd_t                cal_rd;

  // Unpack input item
  assign in_idx = s_axis_tdata[IN_IDX_W-1:0];
  assign in_raw = s_axis_tdata[IN_IDX_W +: SAMPLE_BITS];

  // Effective sensor count and derived limits
  always_comb begin
    if (sensor_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (sensor_count > CNT_W'(MAX_SENSORS)) begin
      n_eff = CNT_W'(MAX_SENSORS);
    end else begin
      n_eff = sensor_count;
    end
    full     = (POS_W+1)'(n_eff) * (POS_W+1)'(NORM_FULL);
    half     = (POS_W+1)'(n_eff) * (POS_W+1)'(NORM_FULL / 2);
    line_thr = (NORM_W+1)'(n_eff) * (NORM_W+1)'(LINE_STEP);
    for (int i = 0; i < MAX_SENSORS; i++) begin
      in_use[i] = (CNT_W'(i) < n_eff);
    end
    cal_ok = &(good | ~in_use);
  end

  // Shared multiplier: offset times full scale, then norm times weight
  always_comb begin
    if (state == ST_MUL2) begin
      mul_a = MUL_A_W'(norm_r);
      mul_b = weight_r;
    end else begin
      mul_a = MUL_A_W'(val_r - cal_rd.lo);
      mul_b = WTOT_W'(NORM_FULL);
    end
    mul_p = (MUL_A_W+WTOT_W)'(mul_a) * (MUL_A_W+WTOT_W)'(mul_b);
  end

  // Saturating accumulate
  assign wsum_add = {1'b0, weighted_sum} + (WSUM_W+1)'(prod_r);
  assign wtot_add = {1'b0, weight_total} + (WTOT_W+1)'(norm_r);

  // Divider operands
  assign pos_divide       = line_seen && (weight_total != '0);
  assign div_req.start    = (state == ST_NSTART) || ((state == ST_POS) && pos_divide);
  assign div_req.dividend = (state == ST_POS) ? DVD_W'(weighted_sum) : prod_r;
  assign div_req.divisor  = (state == ST_POS) ? DVS_W'(weight_total) : range_r;

  lsap_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign cal_wr.en    = (state == ST_CAL);
  assign cal_wr.value = val_r;

  lsap_cal u_cal (
    .clk  (clk),
    .rst  (rst),
    .idx  (idx_r[IDX_W-1:0]),
    .wr   (cal_wr),
    .rd   (cal_rd),
    .good (good)
  );

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_count <= CNT_W'(MAX_SENSORS);
    end else if (cfg_valid && cfg_ready) begin
      sensor_count <= cfg_data;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      weighted_sum  <= '0;
      weight_total  <= '0;
      line_seen     <= 1'b0;
      last_position <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            idx_r  <= in_idx;
            val_r  <= SAMPLE_BITS'(SMAX) - in_raw;
            // drop samples of sensors not in use
            if (CNT_W'(in_idx) < n_eff) begin
              state <= s_axis_tuser ? ST_MUL1 : ST_CAL;
            end
          end
        end
        ST_CAL: begin
          state <= ST_IDLE;
        end
        ST_MUL1: begin
          weight_r <= WTOT_W'((WTOT_W'(idx_r) + WTOT_W'(1)) * WTOT_W'(NORM_FULL));
          if ((cal_rd.hi <= cal_rd.lo) || (val_r <= cal_rd.lo)) begin
            norm_r <= '0;
            state  <= ST_MUL2;
          end else begin
            prod_r  <= DVD_W'(mul_p);
            range_r <= DVS_W'(cal_rd.hi - cal_rd.lo);
            state   <= ST_NSTART;
          end
        end
        ST_NSTART: begin
          state <= ST_NDIV;
        end
        ST_NDIV: begin
          if (div_rsp.done) begin
            norm_r <= (div_rsp.quotient > DVD_W'(NORM_FULL)) ?
                      NORM_W'(NORM_FULL) : NORM_W'(div_rsp.quotient);
            state  <= ST_MUL2;
          end
        end
        ST_MUL2: begin
          prod_r <= DVD_W'(mul_p);
          state  <= ST_ACC;
        end
        ST_ACC: begin
          weighted_sum <= wsum_add[WSUM_W] ? '1 : wsum_add[WSUM_W-1:0];
          weight_total <= wtot_add[WTOT_W] ? '1 : wtot_add[WTOT_W-1:0];
          if ((NORM_W+1)'(norm_r) > line_thr) begin
            line_seen <= 1'b1;
          end
          state <= (CNT_W'(idx_r) == n_eff - CNT_W'(1)) ? ST_POS : ST_IDLE;
        end
        ST_POS: begin
          if (pos_divide) begin
            state <= ST_PDIV;
          end else begin
            // no line: hold the side where it was last seen
            pos_r <= ((POS_W+1)'(last_position) < half) ?
                     POS_W'(NORM_FULL) : POS_W'(full);
            state <= ST_EMIT;
          end
        end
        ST_PDIV: begin
          if (div_rsp.done) begin
            pos_r <= (div_rsp.quotient > DVD_W'(full)) ?
                     POS_W'(full) : POS_W'(div_rsp.quotient);
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_valid || m_axis_tready) begin
            out_pos       <= pos_r;
            out_line      <= line_seen;
            out_cal       <= cal_ok;
            out_valid     <= 1'b1;
            last_position <= pos_r;
            weighted_sum  <= '0;
            weight_total  <= '0;
            line_seen     <= 1'b0;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Ports
  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_W'(out_pos);
  assign m_axis_tuser  = {out_cal, out_line};

`ifndef ASSERT_OFF
  // never take an item while the divider is running
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !div_rsp.busy)
    else $error("item accepted while divider busy");

  // a divider result only lands in a wait state
  assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_NDIV || state == ST_PDIV))
    else $error("divider done outside a wait state");

  // normalized value is clamped before weighting
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL2) |-> (norm_r <= NORM_W'(NORM_FULL)))
    else $error("normalized value above full scale");

  // position never exceeds the array span
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((POS_W+1)'(out_pos) <= (POS_W+1)'(MAX_SENSORS * NORM_FULL)))
    else $error("position beyond array span");
`endif

endmodule
